/* rtl/sensor_frame_deframer_core_assert.svh */
// assertion macros shared by the deframer modules
`ifndef SENSOR_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define SENSOR_FRAME_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// next-cycle implication, disabled while in reset
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

/* rtl/sfd_pkg.sv */
`timescale 1ns / 1ps
package sfd_pkg;

    localparam int FRAME_LEN = 10;
    localparam logic [3:0] LAST_POS = 4'd9;
    localparam logic [3:0] NO_ERROR = 4'd10;

    // field tags
    localparam logic [3:0] TAG_PARITY   = 4'd0;
    localparam logic [3:0] TAG_CITY     = 4'd1;
    localparam logic [3:0] TAG_YEAR     = 4'd2;
    localparam logic [3:0] TAG_MONTH    = 4'd3;
    localparam logic [3:0] TAG_DAY      = 4'd4;
    localparam logic [3:0] TAG_HOUR     = 4'd5;
    localparam logic [3:0] TAG_MINUTE   = 4'd6;
    localparam logic [3:0] TAG_SEQUENCE = 4'd7;
    localparam logic [3:0] TAG_PM       = 4'd8;
    localparam logic [3:0] TAG_GRADE    = 4'd9;
    localparam logic [3:0] TAG_SO2      = 4'd10;
    localparam logic [3:0] TAG_UV       = 4'd11;
    localparam logic [3:0] TAG_TEMP     = 4'd12;
    localparam logic [3:0] TAG_TOTAL    = 4'd13;
    localparam logic [3:0] TAG_ID       = 4'd14;

    // configuration register indexes
    localparam logic [2:0] CFG_MINUTES_PER_SLOT = 3'd0;
    localparam logic [2:0] CFG_BASE_YEAR        = 3'd1;
    localparam logic [2:0] CFG_SO2_LIMIT        = 3'd2;
    localparam logic [2:0] CFG_UV_LIMIT         = 3'd3;
    localparam logic [2:0] CFG_TEMP_HIGH        = 3'd4;
    localparam logic [2:0] CFG_TEMP_LOW         = 3'd5;

    localparam logic [8:0] PM_GRADE1 = 9'd50;
    localparam logic [8:0] PM_GRADE2 = 9'd150;
    localparam logic [8:0] PM_GRADE3 = 9'd300;
    localparam logic [6:0] CITY_MAX  = 7'd9;

    // exact divide by 60 for any 18-bit dividend: (x * DIV60_MUL) >> DIV60_SHIFT
    localparam int MINS_W = 18;
    localparam logic [18:0] DIV60_MUL = 19'd279621;
    localparam int DIV60_SHIFT = 24;

    typedef struct packed {
        logic [3:0]            first_bad;
        logic [9:0][6:0]       data;
    } frame_rec_t;

    typedef struct packed {
        logic [10:0] minutes_per_slot;
        logic [11:0] base_year;
        logic [6:0]  so2_limit;
        logic [6:0]  uv_limit;
        logic [6:0]  temp_high;
        logic [6:0]  temp_low;
    } cfg_t;

endpackage

/* rtl/sfd_front.sv */
`timescale 1ns / 1ps
`include "sensor_frame_deframer_core_assert.svh"
module sfd_front
    import sfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] frame_byte,
    output logic       push_valid,
    input  logic       push_ready,
    output frame_rec_t push_rec
);

    logic [3:0] byte_count_reg, byte_count_next;
    logic [3:0] first_bad_reg, first_bad_next;
    logic [3:0] bad_now;
    logic [6:0] store_reg [FRAME_LEN-1];
    logic       take;
    logic       is_last;

    assign is_last    = (byte_count_reg == LAST_POS);
    assign in_ready   = !is_last || push_ready;
    assign take       = in_valid && in_ready;
    assign push_valid = in_valid && is_last;

    // odd parity: an even count of ones marks a bad byte
    always_comb
    begin
        bad_now = first_bad_reg;
        if ((first_bad_reg == NO_ERROR) && !(^frame_byte))
        begin
            bad_now = byte_count_reg;
        end
    end

    always_comb
    begin
        byte_count_next = byte_count_reg;
        first_bad_next  = first_bad_reg;
        if (take)
        begin
            if (is_last)
            begin
                byte_count_next = 4'd0;
                first_bad_next  = NO_ERROR;
            end
            else
            begin
                byte_count_next = byte_count_reg + 4'd1;
                first_bad_next  = bad_now;
            end
        end
    end

    always_comb
    begin
        push_rec.first_bad = bad_now;
        for (int i = 0; i < FRAME_LEN - 1; i++)
        begin
            push_rec.data[i] = store_reg[i];
        end
        push_rec.data[FRAME_LEN-1] = frame_byte[6:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 4'd0;
            first_bad_reg  <= NO_ERROR;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            first_bad_reg  <= first_bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !is_last)
        begin
            store_reg[byte_count_reg] <= frame_byte[6:0];
        end
    end

    // a recorded parity error always points at a byte already taken
    `SFD_ASSERT_NOW(a_bad_in_frame, clk, rst_n, first_bad_reg != NO_ERROR, first_bad_reg < byte_count_reg)

endmodule

/* rtl/sfd_queue.sv */
`timescale 1ns / 1ps
`include "sensor_frame_deframer_core_assert.svh"
module sfd_queue
    import sfd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  frame_rec_t push_rec,
    output logic       pop_valid,
    input  logic       pop_ready,
    output frame_rec_t pop_rec
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_rec_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_rec    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    `SFD_ASSERT_NEXT(a_pop_drops_count, clk, rst_n, pop && !push, count_reg == $past(count_reg) - CNT_W'(1))

endmodule

/* rtl/sfd_back.sv */
`timescale 1ns / 1ps
`include "sensor_frame_deframer_core_assert.svh"
module sfd_back
    import sfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  frame_rec_t  pop_rec,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  field_tag,
    output logic [12:0] field_value,
    output logic        field_alarm,
    output logic        run_last
);

    frame_rec_t        rec_reg;
    logic              active_reg, active_next;
    logic [3:0]        idx_reg, idx_next;
    logic [6:0]        last_slot_reg, last_slot_next;
    logic [MINS_W-1:0] mins_reg;
    logic [12:0]       quot_reg;
    logic [36:0]       quot_prod;
    logic [18:0]       q60;
    logic [18:0]       rem_wide;
    logic              out_valid_reg;
    logic [3:0]        tag_reg;
    logic [12:0]       value_reg;
    logic              alarm_reg;
    logic              last_reg;

    logic              load;
    logic              issue;
    logic              seq_accept;
    logic              reject_now;
    logic [6:0]        slot;
    logic [8:0]        pm;
    logic [1:0]        grade;
    logic [12:0]       f_value;
    logic              f_alarm;
    logic              f_last;

    assign load      = !active_reg && pop_valid;
    assign pop_ready = load;
    assign issue     = active_reg && (!out_valid_reg || out_ready);

    assign slot = rec_reg.data[3];
    assign pm   = {rec_reg.data[2][6:5], rec_reg.data[4]};

    assign seq_accept = (last_slot_reg == 7'd0)
                     || (({1'b0, last_slot_reg} + 8'd1) == {1'b0, slot});
    assign reject_now = issue && (idx_reg == TAG_SEQUENCE) && !seq_accept;

    // hour by reciprocal multiply, minute by subtracting 60 * hour
    assign quot_prod = {19'd0, mins_reg} * {18'd0, DIV60_MUL};
    assign q60       = {quot_reg, 6'b0} - {4'b0, quot_reg, 2'b0};
    assign rem_wide  = {1'b0, mins_reg} - q60;

    always_comb
    begin
        priority if (pm < PM_GRADE1)
        begin
            grade = 2'd0;
        end
        else if (pm < PM_GRADE2)
        begin
            grade = 2'd1;
        end
        else if (pm < PM_GRADE3)
        begin
            grade = 2'd2;
        end
        else
        begin
            grade = 2'd3;
        end
    end

    always_comb
    begin
        f_value = 13'd0;
        f_alarm = 1'b0;
        f_last  = 1'b0;
        unique case (idx_reg)
            TAG_PARITY:
            begin
                f_value = {9'd0, rec_reg.first_bad};
                f_alarm = (rec_reg.first_bad != NO_ERROR);
            end
            TAG_CITY:
            begin
                f_value = {6'd0, rec_reg.data[0]};
                f_alarm = (rec_reg.data[0] > CITY_MAX);
            end
            TAG_YEAR:     f_value = {1'b0, cfg.base_year} + {10'd0, rec_reg.data[1][6:4]};
            TAG_MONTH:    f_value = {9'd0, rec_reg.data[1][3:0]};
            TAG_DAY:      f_value = {8'd0, rec_reg.data[2][4:0]};
            TAG_HOUR:     f_value = quot_reg;
            TAG_MINUTE:   f_value = {7'd0, rem_wide[5:0]};
            TAG_SEQUENCE:
            begin
                f_value = {12'd0, !seq_accept};
                f_alarm = !seq_accept;
                f_last  = !seq_accept;
            end
            TAG_PM:       f_value = {4'd0, pm};
            TAG_GRADE:
            begin
                f_value = {11'd0, grade};
                f_alarm = (grade == 2'd3);
            end
            TAG_SO2:
            begin
                f_value = {6'd0, rec_reg.data[5]};
                f_alarm = (rec_reg.data[5] > cfg.so2_limit);
            end
            TAG_UV:
            begin
                f_value = {6'd0, rec_reg.data[6]};
                f_alarm = (rec_reg.data[6] > cfg.uv_limit);
            end
            TAG_TEMP:
            begin
                f_value = {6'd0, rec_reg.data[7]};
                f_alarm = (rec_reg.data[7] > cfg.temp_high) || (rec_reg.data[7] < cfg.temp_low);
            end
            TAG_TOTAL:    f_value = {6'd0, rec_reg.data[8]};
            TAG_ID:
            begin
                f_value = {6'd0, rec_reg.data[9]};
                f_last  = 1'b1;
            end
            default:
            begin
                f_value = 13'd0;
                f_alarm = 1'b0;
                f_last  = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        active_next    = active_reg;
        idx_next       = idx_reg;
        last_slot_next = last_slot_reg;
        if (load)
        begin
            active_next = 1'b1;
            idx_next    = TAG_PARITY;
        end
        else if (issue)
        begin
            idx_next = idx_reg + 4'd1;
            if (f_last)
            begin
                active_next = 1'b0;
            end
            if ((idx_reg == TAG_SEQUENCE) && seq_accept)
            begin
                last_slot_next = slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= TAG_PARITY;
            last_slot_reg <= 7'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            last_slot_reg <= last_slot_next;
            if (issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg  <= pop_rec;
            mins_reg <= {7'd0, cfg.minutes_per_slot} * {11'd0, pop_rec.data[3]};
        end
        quot_reg <= quot_prod[DIV60_SHIFT +: 13];
        if (issue)
        begin
            tag_reg   <= idx_reg;
            value_reg <= f_value;
            alarm_reg <= f_alarm;
            last_reg  <= f_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign field_tag   = tag_reg;
    assign field_value = value_reg;
    assign field_alarm = alarm_reg;
    assign run_last    = last_reg;

    `SFD_ASSERT_NEXT(a_load_starts_run, clk, rst_n, load, active_reg && (idx_reg == TAG_PARITY))
    `SFD_ASSERT_NEXT(a_reject_ends_run, clk, rst_n, reject_now, out_valid_reg && last_reg && !active_reg)

endmodule

/* rtl/sensor_frame_deframer_core.sv */
// data path: front, queue, the back end's frame register, then the output register
// input: one byte per cycle while in_ready is high; output: one field per cycle within a
//   run while out_ready allows, 15 fields or 8 on a reject; the back end loads a frame,
//   issues its fields and only then loads the next one
// reset: rst_n asynchronous, clears counters, queue, slot history and output valid,
//   and returns the configuration registers to their defaults
`timescale 1ns / 1ps
module sensor_frame_deframer_core
    import sfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2   // frames buffered between front and back, 2 or more
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    // byte input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  frame_byte,
    // field output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  field_tag,
    output logic [12:0] field_value,
    output logic        field_alarm,
    output logic        run_last
);

    // configuration registers: the user writes only while the block is idle; not enforced
    cfg_t       cfg_reg;

    // front to queue transfer
    logic       push_valid;
    logic       push_ready;
    frame_rec_t push_rec;

    // queue to back transfer
    logic       pop_valid;
    logic       pop_ready;
    frame_rec_t pop_rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.minutes_per_slot <= 11'd14;
            cfg_reg.base_year        <= 12'd2017;
            cfg_reg.so2_limit        <= 7'd20;
            cfg_reg.uv_limit         <= 7'd7;
            cfg_reg.temp_high        <= 7'd30;
            cfg_reg.temp_low         <= 7'd5;
        end
        else if (cfg_wr_en)
        begin
            // indexes beyond the list are ignored
            unique case (cfg_index)
                CFG_MINUTES_PER_SLOT: cfg_reg.minutes_per_slot <= cfg_data[10:0];
                CFG_BASE_YEAR:        cfg_reg.base_year        <= cfg_data;
                CFG_SO2_LIMIT:        cfg_reg.so2_limit        <= cfg_data[6:0];
                CFG_UV_LIMIT:         cfg_reg.uv_limit         <= cfg_data[6:0];
                CFG_TEMP_HIGH:        cfg_reg.temp_high        <= cfg_data[6:0];
                CFG_TEMP_LOW:         cfg_reg.temp_low         <= cfg_data[6:0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // front: gathers bytes, tracks the first parity failure, hands over whole frames
    sfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .frame_byte (frame_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec)
    );

    // short frame queue so the front keeps taking bytes while a run drains
    sfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    // back: decodes a field per unstalled cycle to the output register; checks slot order
    sfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_rec     (pop_rec),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .field_tag   (field_tag),
        .field_value (field_value),
        .field_alarm (field_alarm),
        .run_last    (run_last)
    );

endmodule

/* verif/sensor_frame_deframer_checker.sv */
`timescale 1ns / 1ps
module sensor_frame_deframer_checker
    import sfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  frame_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [3:0]  field_tag,
    input  logic [12:0] field_value,
    input  logic        field_alarm,
    input  logic        run_last,
    output int          error_count,
    output int          fields_due
);

    typedef struct packed {
        logic [3:0]  tag;
        logic [12:0] value;
        logic        alarm;
        logic        last;
    } field_t;

    typedef enum logic [1:0] {GRADE_GOOD, GRADE_FAIR, GRADE_POOR, GRADE_WORST} grade_t;

    cfg_t       cfg;
    logic [3:0] byte_pos;
    logic [7:0] frame_bytes [FRAME_LEN];
    logic [3:0] first_bad;
    logic [6:0] last_slot;
    field_t     due_fields [$];
    field_t     want_field;

    task automatic report(input string what, input int got, input int want);
        $display("deframer check @%0t: %s got %0d want %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic push_field(input logic [3:0] tag, input logic [12:0] value,
                              input logic alarm, input logic last);
        due_fields.push_back('{tag: tag, value: value, alarm: alarm, last: last});
    endtask

    // fields of one complete frame, in the order the block sends them
    task automatic decode_frame();
        logic [6:0]  city;
        logic [6:0]  slot;
        logic [8:0]  pm;
        logic [6:0]  temp;
        logic [12:0] year;
        int unsigned mins;
        logic        accept;
        grade_t      grade;
        push_field(TAG_PARITY, 13'(first_bad), first_bad != NO_ERROR, 1'b0);
        city = frame_bytes[0][6:0];
        push_field(TAG_CITY, 13'(city), city > CITY_MAX, 1'b0);
        year = {1'b0, cfg.base_year} + {10'd0, frame_bytes[1][6:4]};
        push_field(TAG_YEAR, year, 1'b0, 1'b0);
        push_field(TAG_MONTH, 13'(frame_bytes[1][3:0]), 1'b0, 1'b0);
        push_field(TAG_DAY, 13'(frame_bytes[2][4:0]), 1'b0, 1'b0);
        slot = frame_bytes[3][6:0];
        mins = 32'(cfg.minutes_per_slot) * 32'(slot);
        push_field(TAG_HOUR, 13'(mins / 60), 1'b0, 1'b0);
        push_field(TAG_MINUTE, 13'(mins % 60), 1'b0, 1'b0);
        // slot must follow the last accepted one, unless none yet
        accept = (last_slot == '0) || ({1'b0, last_slot} + 8'd1 == {1'b0, slot});
        if (accept)
        begin
            last_slot = slot;
        end
        push_field(TAG_SEQUENCE, 13'(!accept), !accept, !accept);
        if (accept)
        begin
            pm = {frame_bytes[2][6:5], frame_bytes[4][6:0]};
            if (pm < PM_GRADE1)
                grade = GRADE_GOOD;
            else if (pm < PM_GRADE2)
                grade = GRADE_FAIR;
            else if (pm < PM_GRADE3)
                grade = GRADE_POOR;
            else
                grade = GRADE_WORST;
            push_field(TAG_PM, 13'(pm), 1'b0, 1'b0);
            push_field(TAG_GRADE, 13'(grade), grade == GRADE_WORST, 1'b0);
            push_field(TAG_SO2, 13'(frame_bytes[5][6:0]),
                       frame_bytes[5][6:0] > cfg.so2_limit, 1'b0);
            push_field(TAG_UV, 13'(frame_bytes[6][6:0]),
                       frame_bytes[6][6:0] > cfg.uv_limit, 1'b0);
            temp = frame_bytes[7][6:0];
            push_field(TAG_TEMP, 13'(temp), temp > cfg.temp_high || temp < cfg.temp_low, 1'b0);
            push_field(TAG_TOTAL, 13'(frame_bytes[8][6:0]), 1'b0, 1'b0);
            push_field(TAG_ID, 13'(frame_bytes[9][6:0]), 1'b0, 1'b1);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.minutes_per_slot = 11'd14;
            cfg.base_year        = 12'd2017;
            cfg.so2_limit        = 7'd20;
            cfg.uv_limit         = 7'd7;
            cfg.temp_high        = 7'd30;
            cfg.temp_low         = 7'd5;
            byte_pos             = '0;
            first_bad            = NO_ERROR;
            last_slot            = '0;
            due_fields.delete();
            fields_due <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_fields.size() == 0)
                begin
                    report("field with nothing due, tag", int'(field_tag), -1);
                end
                else
                begin
                    want_field = due_fields.pop_front();
                    if (field_tag !== want_field.tag)
                        report("field_tag", int'(field_tag), int'(want_field.tag));
                    if (field_value !== want_field.value)
                        report($sformatf("field_value of tag %0d", want_field.tag),
                               int'(field_value), int'(want_field.value));
                    if (field_alarm !== want_field.alarm)
                        report($sformatf("field_alarm of tag %0d", want_field.tag),
                               int'(field_alarm), int'(want_field.alarm));
                    if (run_last !== want_field.last)
                        report($sformatf("run_last of tag %0d", want_field.tag),
                               int'(run_last), int'(want_field.last));
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MINUTES_PER_SLOT: cfg.minutes_per_slot = cfg_data[10:0];
                    CFG_BASE_YEAR:        cfg.base_year        = cfg_data[11:0];
                    CFG_SO2_LIMIT:        cfg.so2_limit        = cfg_data[6:0];
                    CFG_UV_LIMIT:         cfg.uv_limit         = cfg_data[6:0];
                    CFG_TEMP_HIGH:        cfg.temp_high        = cfg_data[6:0];
                    CFG_TEMP_LOW:         cfg.temp_low         = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                frame_bytes[byte_pos] = frame_byte;
                if (first_bad == NO_ERROR && !(^frame_byte))
                    first_bad = byte_pos;
                if (byte_pos == LAST_POS)
                begin
                    decode_frame();
                    byte_pos  = '0;
                    first_bad = NO_ERROR;
                end
                else
                begin
                    byte_pos = byte_pos + 4'd1;
                end
            end
            fields_due <= due_fields.size();
        end
    end

endmodule

/* verif/sensor_frame_deframer_core_test.sv */
`timescale 1ns / 1ps
module sensor_frame_deframer_core_test;
    import sfd_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int PHASE_FRAMES  = 8;
    localparam int NUM_PHASES    = 5;
    localparam int SETTLE_CYCLES = 8;       // spare cycles after the due fields arrive
    localparam int CYCLE_LIMIT   = 200000;  // watchdog limit on the whole simulation

    // decoded content of one frame, plus which bytes get their parity spoilt
    typedef struct packed {
        logic [6:0] city;
        logic [2:0] year_ofs;
        logic [3:0] month;
        logic [4:0] day;
        logic [6:0] slot;
        logic [8:0] pm;
        logic [6:0] so2;
        logic [6:0] uv;
        logic [6:0] temp;
        logic [6:0] total;
        logic [6:0] id;
        logic [9:0] bad;
    } frame_t;

    typedef enum {READY_ALWAYS, READY_RANDOM, READY_PERIODIC, READY_LONG_STALLS} ready_mode_t;

    // every input driven to a known value from time zero
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_wr_en  = 1'b0;
    logic [2:0]  cfg_index  = CFG_MINUTES_PER_SLOT;
    logic [11:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic [7:0]  frame_byte = '0;
    logic        out_ready  = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [3:0]  field_tag;
    logic [12:0] field_value;
    logic        field_alarm;
    logic        run_last;
    int          error_count;
    int          fields_due;

    int          cycle_count = 0;
    int          burst_left  = 0;
    logic [6:0]  seq_slot    = '0;   // slot history as the block should hold it
    logic [6:0]  start_slot  = '0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    sensor_frame_deframer_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .frame_byte  (frame_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .field_tag   (field_tag),
        .field_value (field_value),
        .field_alarm (field_alarm),
        .run_last    (run_last)
    );

    // watches both channels and the register port, predicts and compares
    sensor_frame_deframer_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .frame_byte  (frame_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .field_tag   (field_tag),
        .field_value (field_value),
        .field_alarm (field_alarm),
        .run_last    (run_last),
        .error_count (error_count),
        .fields_due  (fields_due)
    );

    // watchdog: a hung handshake or a field that never arrives ends up here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("sensor_frame_deframer_core: mismatch");
            $finish;
        end
    end

    // receiver back-pressure: switches at random between behaviours,
    // including stretches where it never stalls at all
    ready_mode_t ready_mode = READY_ALWAYS;
    int          mode_left  = 0;
    int          stall_run  = 0;

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(30, 200);
        end
        mode_left--;
        case (ready_mode)
            READY_ALWAYS:   out_ready <= 1'b1;
            READY_RANDOM:   out_ready <= ($urandom_range(0, 2) != 0);
            READY_PERIODIC: out_ready <= (mode_left % 5 < 3);
            default:
            begin
                // mostly ready, with the odd long stall
                if (stall_run > 0)
                begin
                    stall_run--;
                    out_ready <= 1'b0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    stall_run = $urandom_range(5, 20);
                    out_ready <= 1'b0;
                end
                else
                begin
                    out_ready <= 1'b1;
                end
            end
        endcase
    end

    // one byte transfer; bursts of random length separated by random gaps,
    // a quarter of the gaps being zero so bursts also run back to back
    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge clk);
        in_valid   <= 1'b1;
        frame_byte <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // pack the fields into ten bytes with odd parity in bit 7, spoiling the
    // parity of the bytes marked bad
    task automatic send_frame(input frame_t f);
        logic [6:0] body [FRAME_LEN];
        body[0] = f.city;
        body[1] = {f.year_ofs, f.month};
        body[2] = {f.pm[8:7], f.day};
        body[3] = f.slot;
        body[4] = f.pm[6:0];
        body[5] = f.so2;
        body[6] = f.uv;
        body[7] = f.temp;
        body[8] = f.total;
        body[9] = f.id;
        for (int i = 0; i < FRAME_LEN; i++)
            send_byte({~(^body[i]) ^ f.bad[i], body[i]});
        // follow the slot history so well-formed runs keep counting up
        if (seq_slot == '0 || {1'b0, seq_slot} + 8'd1 == {1'b0, f.slot})
            seq_slot = f.slot;
    endtask

    function automatic frame_t random_frame(input logic well_formed);
        frame_t  f;
        logic [8:0] pm_edges [10] = '{9'd0, 9'd49, 9'd50, 9'd149, 9'd150,
                                      9'd299, 9'd300, 9'd399, 9'd400, 9'd511};
        f.city     = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 9))
                                                 : 7'($urandom_range(0, 127));
        f.year_ofs = 3'($urandom_range(0, 7));
        f.month    = 4'($urandom_range(0, 15));
        f.day      = 5'($urandom_range(0, 31));
        f.pm       = ($urandom_range(0, 3) == 0) ? pm_edges[4'($urandom_range(0, 9))]
                                                 : 9'($urandom_range(0, 511));
        f.so2      = 7'($urandom_range(0, 127));
        f.uv       = 7'($urandom_range(0, 127));
        f.temp     = 7'($urandom_range(0, 127));
        f.total    = 7'($urandom_range(0, 127));
        f.id       = 7'($urandom_range(0, 127));
        // mostly clean, otherwise one spoilt byte or a scatter of them
        case ($urandom_range(0, 5))
            0:       f.bad = 10'd1 << $urandom_range(0, 9);
            1:       f.bad = 10'($urandom_range(1, 1023));
            default: f.bad = '0;
        endcase
        if (well_formed)
        begin
            if (seq_slot == '0)
                f.slot = start_slot;
            else if (seq_slot == 7'd127)
                f.slot = 7'($urandom_range(0, 127));   // nothing can follow the top slot
            else
                f.slot = seq_slot + 7'd1;
        end
        else
        begin
            // out-of-order slot: anything, a repeat, or one skipped
            case ($urandom_range(0, 2))
                0:       f.slot = 7'($urandom_range(0, 127));
                1:       f.slot = seq_slot;
                default: f.slot = seq_slot + 7'd2;
            endcase
        end
        return f;
    endfunction

    // register writes on consecutive cycles, enable dropped after the last
    task automatic write_config(input logic [10:0] minutes, input logic [11:0] year,
                                input logic [6:0] so2, input logic [6:0] uv,
                                input logic [6:0] hot, input logic [6:0] cold);
        logic [2:0]  idx  [6] = '{CFG_MINUTES_PER_SLOT, CFG_BASE_YEAR, CFG_SO2_LIMIT,
                                  CFG_UV_LIMIT, CFG_TEMP_HIGH, CFG_TEMP_LOW};
        logic [11:0] data [6];
        data = '{{1'b0, minutes}, year, {5'd0, so2}, {5'd0, uv}, {5'd0, hot}, {5'd0, cold}};
        for (int i = 0; i < 6; i++)
        begin
            @(negedge clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= data[i];
        end
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // stop sending and let every due field arrive, then wait out SETTLE_CYCLES
    task automatic drain_fields();
        @(negedge clk);
        in_valid <= 1'b0;
        while (fields_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        frame_t f;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // a first accepted slot that lets the well-formed run climb to the top slot
        start_slot = 7'($urandom_range(92, 96));

        // directed, reset configuration: every field at its maximum with slot zero
        // (accepted, history stays empty) and a bad last byte
        f      = '1;
        f.slot = '0;
        f.bad  = 10'h200;
        send_frame(f);
        // every field at zero, every byte with bad parity, still no slot history
        f      = '0;
        f.bad  = 10'h3ff;
        send_frame(f);
        drain_fields();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: write_config(11'($urandom_range(0, 2047)), 12'($urandom_range(0, 4095)),
                                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
                // zero minutes per slot and every limit at its tightest
                1: write_config(11'd0, 12'd0, 7'd0, 7'd0, 7'd0, 7'd127);
                // one minute per slot, latest base year, limits fully open
                2: write_config(11'd1, 12'd4095, 7'd127, 7'd127, 7'd127, 7'd0);
                3: write_config(11'd1440, 12'($urandom_range(0, 4095)),
                                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
                default: write_config(11'd2047, 12'd4095, 7'd0, 7'd127, 7'd64, 7'd64);
            endcase
            repeat (PHASE_FRAMES)
                send_frame(random_frame($urandom_range(0, 4) != 0));
            drain_fields();
        end

        if (error_count == 0)
            $display("sensor_frame_deframer_core: match");
        else
            $display("sensor_frame_deframer_core: mismatch");
        $finish;
    end

endmodule
